FILE: rtl/nba_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the nearest bone assignment unit.
// No dependencies; imported by the controller, the datapath and the top level.
package nba_pkg;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_BAD_BONE = 2'd2;

   // 34-bit squared distance -> 17 root digits
   localparam int SQRT_STEPS = 17;

   typedef struct packed {
      logic [1:0]         operation;
      logic [3:0]         bone_select;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [3:0]  bone_number;
      logic [16:0] bone_distance;
      logic        bone_empty;
      logic [3:0]  closest_bone;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_SQUARE,
      ST_ACCUM,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan_start;
      logic rd_en;
      logic sq_en;
      logic acc_en;
      logic sqrt_start;
      logic sqrt_step;
      logic emit_bone;
      logic bone_next;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic       rsp_free;
      logic       pt_more;
      logic       bone_any;
      logic       bone_last;
      logic       sqrt_done;
   } stat_type;

endpackage

FILE: rtl/nba_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the nearest bone assignment unit: walks bones and points.
// Depends on nba_pkg; drives the datapath through cmd_type and reads stat_type.
module nba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nba_pkg::stat_type stat,
   output nba_pkg::cmd_type  cmd
);
   import nba_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.rsp_free && stat.req_op == OP_QUERY) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (stat.pt_more) begin
               state_in = ST_READ;
            end else if (stat.bone_any) begin
               state_in = ST_ROOT;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_READ:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ACCUM;
         ST_ACCUM:  state_in = ST_CHECK;
         ST_ROOT: begin
            if (stat.sqrt_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.rsp_free) begin
               state_in = stat.bone_last ? ST_IDLE : ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready      = stat.rsp_free;
            cmd.accept     = req_valid && stat.rsp_free;
            cmd.scan_start = cmd.accept && stat.req_op == OP_QUERY;
         end
         ST_CHECK: begin
            cmd.sqrt_start = !stat.pt_more && stat.bone_any;
         end
         ST_READ:   cmd.rd_en  = 1'b1;
         ST_SQUARE: cmd.sq_en  = 1'b1;
         ST_ACCUM:  cmd.acc_en = 1'b1;
         ST_ROOT:   cmd.sqrt_step = !stat.sqrt_done;
         ST_EMIT: begin
            cmd.emit_bone = stat.rsp_free;
            cmd.bone_next = stat.rsp_free && !stat.bone_last;
         end
         default: ;
      endcase
   end

endmodule

FILE: rtl/nba_dp.sv
`timescale 1ns / 1ps
// Datapath: point store, per-bone counts, distance unit, square root and result register.
// Depends on nba_pkg; commanded by nba_ctrl.
module nba_dp #(
   parameter int MAX_BONES           = 16,
   parameter int MAX_POINTS_PER_BONE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data,
   input  nba_pkg::req_type  req_data,
   input  nba_pkg::cmd_type  cmd,
   output nba_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nba_pkg::rsp_type  rsp_data
);
   import nba_pkg::*;

   localparam int BIW   = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam int CW    = $clog2(MAX_POINTS_PER_BONE + 1);
   localparam int DEPTH = MAX_BONES * MAX_POINTS_PER_BONE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BCW   = $clog2(MAX_BONES + 1);
   localparam int NW    = (BCW > 5) ? BCW : 5;
   localparam int SCW   = $clog2(SQRT_STEPS + 1);

   logic [4:0]        biu_ff;
   logic [CW-1:0]     cnt_ff [MAX_BONES];
   logic [47:0]       mem [DEPTH];
   logic [47:0]       rd_data_ff;
   logic signed [15:0] vx_ff, vy_ff, vz_ff;
   logic [BIW-1:0]    bone_ff;
   logic [CW-1:0]     k_ff;
   logic [31:0]       sqx_ff, sqy_ff, sqz_ff;
   logic [33:0]       best_ff, bmin_ff;
   logic              have_best_ff, bany_ff;
   logic [BIW-1:0]    closest_ff;
   logic [33:0]       val_ff;
   logic [18:0]       rem_ff;
   logic [16:0]       root_ff;
   logic [SCW-1:0]    scnt_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [BIW-1:0]    sel_idx;
   logic              sel_ok;
   logic [BIW-1:0]    cidx;
   logic [CW-1:0]     cnt_rd;
   logic              is_add, is_clear, can_add;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [NW-1:0]     nlim;
   logic              rsp_free;
   logic signed [16:0] dx, dy, dz;
   logic [15:0]       ax, ay, az;
   logic [33:0]       dsum;
   logic [20:0]       rem_sh, trial;

   assign sel_idx  = BIW'(req_data.bone_select);
   assign sel_ok   = int'(req_data.bone_select) < MAX_BONES;
   assign cidx     = cmd.accept ? sel_idx : bone_ff;
   assign cnt_rd   = cnt_ff[cidx];
   assign is_add   = cmd.accept && req_data.operation == OP_ADD;
   assign is_clear = cmd.accept && req_data.operation == OP_CLEAR;
   assign can_add  = is_add && sel_ok && int'(cnt_rd) < MAX_POINTS_PER_BONE;
   assign wr_addr  = AW'(sel_idx) * AW'(MAX_POINTS_PER_BONE) + AW'(cnt_rd);
   assign rd_addr  = AW'(bone_ff) * AW'(MAX_POINTS_PER_BONE) + AW'(k_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Saturate bones in use to 1..MAX_BONES.
   always_comb begin
      priority if (biu_ff == '0) begin
         nlim = NW'(1);
      end else if (int'(biu_ff) > MAX_BONES) begin
         nlim = NW'(MAX_BONES);
      end else begin
         nlim = NW'(biu_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         biu_ff <= 5'd16;
      end else if (csr_wr_en) begin
         biu_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BONES; i++) cnt_ff[i] <= '0;
      end else if (is_clear) begin
         for (int i = 0; i < MAX_BONES; i++) cnt_ff[i] <= '0;
      end else if (can_add) begin
         cnt_ff[sel_idx] <= cnt_rd + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (can_add) begin
         mem[wr_addr] <= {req_data.coord_z, req_data.coord_y, req_data.coord_x};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Distance: squares, then sum and compare.
   assign dx = 17'(signed'(rd_data_ff[15:0]))  - 17'(vx_ff);
   assign dy = 17'(signed'(rd_data_ff[31:16])) - 17'(vy_ff);
   assign dz = 17'(signed'(rd_data_ff[47:32])) - 17'(vz_ff);
   assign ax = dx[16] ? 16'(-dx) : dx[15:0];
   assign ay = dy[16] ? 16'(-dy) : dy[15:0];
   assign az = dz[16] ? 16'(-dz) : dz[15:0];
   assign dsum = 34'(sqx_ff) + 34'(sqy_ff) + 34'(sqz_ff);

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         vx_ff <= req_data.coord_x;
         vy_ff <= req_data.coord_y;
         vz_ff <= req_data.coord_z;
      end
      if (cmd.sq_en) begin
         sqx_ff <= ax * ax;
         sqy_ff <= ay * ay;
         sqz_ff <= az * az;
      end
      if (cmd.acc_en) begin
         if (!have_best_ff || dsum < best_ff) begin
            best_ff    <= dsum;
            closest_ff <= bone_ff;
         end
         if (!bany_ff || dsum < bmin_ff) begin
            bmin_ff <= dsum;
         end
      end
      if (cmd.scan_start) begin
         closest_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bone_ff      <= '0;
         k_ff         <= '0;
         have_best_ff <= 1'b0;
         bany_ff      <= 1'b0;
      end else if (cmd.scan_start) begin
         bone_ff      <= '0;
         k_ff         <= '0;
         have_best_ff <= 1'b0;
         bany_ff      <= 1'b0;
      end else if (cmd.bone_next) begin
         bone_ff <= bone_ff + BIW'(1);
         k_ff    <= '0;
         bany_ff <= 1'b0;
      end else if (cmd.acc_en) begin
         k_ff         <= k_ff + CW'(1);
         have_best_ff <= 1'b1;
         bany_ff      <= 1'b1;
      end
   end

   // Square root, two radicand bits per step.
   assign rem_sh = {rem_ff, val_ff[33:32]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         val_ff  <= bmin_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         val_ff <= {val_ff[31:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= 19'(rem_sh - trial);
            root_ff <= {root_ff[15:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[18:0];
            root_ff <= {root_ff[15:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scnt_ff <= '0;
      end else if (cmd.sqrt_start) begin
         scnt_ff <= SCW'(SQRT_STEPS);
      end else if (cmd.sqrt_step) begin
         scnt_ff <= scnt_ff - SCW'(1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (is_add || is_clear || cmd.emit_bone) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (is_add || is_clear) begin
         rsp_ff.bone_number   <= '0;
         rsp_ff.bone_distance <= '0;
         rsp_ff.bone_empty    <= 1'b0;
         rsp_ff.closest_bone  <= '0;
         rsp_ff.last          <= 1'b1;
         priority if (is_clear) begin
            rsp_ff.status <= STAT_OK;
         end else if (!sel_ok) begin
            rsp_ff.status <= STAT_BAD_BONE;
         end else if (!can_add) begin
            rsp_ff.status <= STAT_FULL;
         end else begin
            rsp_ff.status <= STAT_OK;
         end
      end else if (cmd.emit_bone) begin
         rsp_ff.bone_number   <= 4'(bone_ff);
         rsp_ff.bone_distance <= bany_ff ? root_ff : '0;
         rsp_ff.bone_empty    <= !bany_ff;
         rsp_ff.closest_bone  <= stat.bone_last ? 4'(closest_ff) : 4'd0;
         rsp_ff.status        <= STAT_OK;
         rsp_ff.last          <= stat.bone_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign stat.req_op    = req_data.operation;
   assign stat.rsp_free  = rsp_free;
   assign stat.pt_more   = k_ff < cnt_rd;
   assign stat.bone_any  = bany_ff;
   assign stat.bone_last = NW'(bone_ff) == nlim - NW'(1);
   assign stat.sqrt_done = scnt_ff == '0;

`ifndef ASSERT_OFF
   a_acc_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_en |-> k_ff < cnt_rd)
      else $error("point index past bone count");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (is_add || is_clear || cmd.emit_bone) |-> rsp_free)
      else $error("result register overwritten while held");
   a_sqrt_count: assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_step |-> scnt_ff != '0)
      else $error("square root stepped past its last digit");
   a_emit_ready_root: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_bone && bany_ff) |-> scnt_ff == '0)
      else $error("bone result emitted before root finished");
`endif

endmodule

FILE: rtl/nearest_bone_assign_unit.sv
`timescale 1ns / 1ps
// Nearest bone assignment unit: top level joining nba_ctrl and nba_dp (uses nba_pkg).
// Clear and add transactions are taken in idle; their result is registered in the next cycle.
// Query: for each bone, every point is read, squared and accumulated in turn, then the
// square root is taken if the bone has points, then the bone result is emitted.
// One transaction is worked at a time. Synchronous active-high reset empties all
// bones and sets bones in use to 16; stored point values are not cleared.
module nearest_bone_assign_unit #(
   parameter int MAX_BONES           = 16,
   parameter int MAX_POINTS_PER_BONE = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  nba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nba_pkg::rsp_type rsp_data
);
   import nba_pkg::*;

   // Commands flow down to the datapath, status comes back up.
   cmd_type  cmd;
   stat_type stat;

   // Sequencer: accept transactions, walk bones and points, pace the output.
   nba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: store, counts, distance, root, and the result register.
   nba_dp #(
      .MAX_BONES           (MAX_BONES),
      .MAX_POINTS_PER_BONE (MAX_POINTS_PER_BONE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: sim/nearest_bone_assign_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for nearest_bone_assign_unit: clear, add and query transactions
// against an in-bench bone distance predictor. Depends on nba_pkg and the unit RTL.
module nearest_bone_assign_unit_tb;
   import nba_pkg::*;

   localparam int NBONES   = 16;
   localparam int NPOINTS  = 64;
   localparam int CYC_LIMIT = 20000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_wr_en = 1'b0;
   logic [4:0] csr_wr_data = 5'd0;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   nearest_bone_assign_unit uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // predictor state: mirror of point store, counts and bones in use
   logic signed [15:0] mirror_x [NBONES*NPOINTS];
   logic signed [15:0] mirror_y [NBONES*NPOINTS];
   logic signed [15:0] mirror_z [NBONES*NPOINTS];
   int unsigned        mirror_count [NBONES];
   logic [4:0]         mirror_bones;

   rsp_type expected_rsps [$];
   int      mismatch_count = 0;
   int      rsp_total = 0;
   int      req_total = 0;
   int      cycle_count = 0;
   bit      quiet_mode = 0;     // no random idling on either side
   bit      hold_rsp = 0;       // long receiver hold-off

   function automatic logic [16:0] floor_root(logic [33:0] v);
      logic [33:0] r;
      r = 0;
      for (int b = 16; b >= 0; b--)
         if ((r | (34'd1 << b)) * (r | (34'd1 << b)) <= v) r = r | (34'd1 << b);
      return r[16:0];
   endfunction

   function automatic logic [33:0] dist_sq(int i, req_type q);
      longint dx, dy, dz;
      dx = longint'(mirror_x[i]) - longint'(q.coord_x);
      dy = longint'(mirror_y[i]) - longint'(q.coord_y);
      dz = longint'(mirror_z[i]) - longint'(q.coord_z);
      return 34'(dx*dx + dy*dy + dz*dz);
   endfunction

   task automatic predict_bone_results(req_type q);
      rsp_type r;
      int n, idx;
      bit have_best, bany;
      logic [33:0] best, bmin, d;
      logic [3:0] closest;
      r = '0;
      r.last = 1'b1;
      if (q.operation == OP_CLEAR) begin
         foreach (mirror_count[b]) mirror_count[b] = 0;
         expected_rsps.push_back(r);
      end else if (q.operation == OP_ADD) begin
         if (mirror_count[q.bone_select] >= NPOINTS) begin
            r.status = STAT_FULL;
         end else begin
            idx = q.bone_select * NPOINTS + mirror_count[q.bone_select];
            mirror_x[idx] = q.coord_x;
            mirror_y[idx] = q.coord_y;
            mirror_z[idx] = q.coord_z;
            mirror_count[q.bone_select]++;
         end
         expected_rsps.push_back(r);
      end else if (q.operation == OP_QUERY) begin
         n = mirror_bones;
         if (n == 0) n = 1;
         if (n > NBONES) n = NBONES;
         have_best = 0; best = 0; closest = 0;
         for (int b = 0; b < n; b++) begin
            bany = 0; bmin = 0;
            for (int k = 0; k < mirror_count[b]; k++) begin
               d = dist_sq(b*NPOINTS + k, q);
               if (!have_best || d < best) begin
                  have_best = 1; best = d; closest = 4'(b);
               end
               if (!bany || d < bmin) begin
                  bany = 1; bmin = d;
               end
            end
            r = '0;
            r.bone_number   = 4'(b);
            r.bone_distance = bany ? floor_root(bmin) : 17'd0;
            r.bone_empty    = !bany;
            if (b == n-1) begin
               r.closest_bone = closest;
               r.last = 1'b1;
            end
            expected_rsps.push_back(r);
         end
      end
      // any other operation code: ignored, no result
   endtask

   // send one transaction; valid held steady until accepted, dropped only while idling
   task automatic send_transaction(req_type q);
      while (!quiet_mode && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      predict_bone_results(q);
      req_total++;
   endtask

   task automatic write_bones(logic [4:0] v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mirror_bones = v;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);   // ignored ops may still be in flight
   endtask

   function automatic req_type make_req(logic [1:0] op, logic [3:0] sel,
                                        logic [15:0] x, logic [15:0] y, logic [15:0] z);
      req_type q;
      q.operation = op; q.bone_select = sel;
      q.coord_x = x; q.coord_y = y; q.coord_z = z;
      return q;
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver: random stalls, with hold-off and quiet stretches
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else if (quiet_mode) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 21);
   end

   // response checker: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_total <= rsp_total + 1;
         if (expected_rsps.size() == 0) begin
            $error("unexpected result: %p", rsp_data);
            mismatch_count <= mismatch_count + 1;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               mismatch_count <= mismatch_count + 1;
               if (rsp_data.bone_number !== want.bone_number)
                  $error("bone_number exp %0d got %0d", want.bone_number, rsp_data.bone_number);
               if (rsp_data.bone_distance !== want.bone_distance)
                  $error("bone_distance exp %0d got %0d",
                         want.bone_distance, rsp_data.bone_distance);
               if (rsp_data.bone_empty !== want.bone_empty)
                  $error("bone_empty exp %0d got %0d", want.bone_empty, rsp_data.bone_empty);
               if (rsp_data.closest_bone !== want.closest_bone)
                  $error("closest_bone exp %0d got %0d",
                         want.closest_bone, rsp_data.closest_bone);
               if (rsp_data.status !== want.status)
                  $error("status exp %0d got %0d", want.status, rsp_data.status);
               if (rsp_data.last !== want.last)
                  $error("last exp %0d got %0d", want.last, rsp_data.last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count >= CYC_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // directed: extremes, every operation, ties, empty bones, op three
   task automatic test_directed();
      send_transaction(make_req(OP_QUERY, 0, 0, 0, 0));          // all bones empty
      send_transaction(make_req(OP_ADD, 3, 16'h8000, 16'h8000, 16'h8000));
      send_transaction(make_req(OP_ADD, 3, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_transaction(make_req(OP_QUERY, 4'hF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_transaction(make_req(OP_QUERY, 0, 16'h8000, 16'h7FFF, 16'h8000)); // max dist
      send_transaction(make_req(OP_ADD, 5, 16'h0100, 0, 0));     // tie with bone 7
      send_transaction(make_req(OP_ADD, 7, 16'hFF00, 0, 0));
      send_transaction(make_req(OP_ADD, 15, 16'h1234, 16'hEDCB, 16'h0F0F));
      send_transaction(make_req(OP_QUERY, 0, 0, 0, 0));
      send_transaction(make_req(2'd3, 4'hA, 16'h5555, 16'hAAAA, 16'h5555)); // ignored
      send_transaction(make_req(OP_CLEAR, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_transaction(make_req(OP_QUERY, 0, 0, 0, 0));
   endtask

   task automatic test_full_bone();
      for (int k = 0; k < NPOINTS + 2; k++)
         send_transaction(make_req(OP_ADD, 2, rand_coord(), rand_coord(), rand_coord()));
      send_transaction(make_req(OP_QUERY, 0, rand_coord(), rand_coord(), rand_coord()));
   endtask

   task automatic test_bones_setting();
      logic [4:0] vals [5] = '{5'd1, 5'd0, 5'd31, 5'd7, 5'd16};
      foreach (vals[i]) begin
         write_bones(vals[i]);
         send_transaction(make_req(OP_QUERY, 0, rand_coord(), rand_coord(), rand_coord()));
      end
   endtask

   // receiver held off while the sender keeps offering transactions
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 8; i++)
            send_transaction(make_req(OP_ADD, 4'($urandom), rand_coord(), rand_coord(),
                                      rand_coord()));
      join
   endtask

   // random mix: mostly adds with a small point budget, some queries and clears
   task automatic test_random(int count);
      logic [1:0] op;
      int roll;
      for (int i = 0; i < count; i++) begin
         quiet_mode = (i >= count/2 && i < count/2 + 60);
         roll = $urandom_range(99);
         if (roll < 3) op = OP_CLEAR;
         else if (roll < 70) op = OP_ADD;
         else if (roll < 98) op = OP_QUERY;
         else op = 2'd3;
         if (i == count/3) begin
            quiet_mode = 0;
            write_bones(5'($urandom_range(1, 16)));
         end
         send_transaction(make_req(op, 4'($urandom), rand_coord(), rand_coord(),
                                   rand_coord()));
      end
      quiet_mode = 0;
   endtask

   initial begin
      foreach (mirror_count[b]) mirror_count[b] = 0;
      mirror_bones = 5'd16;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_bone();
      test_bones_setting();
      test_backpressure();
      test_random(410);
      wait_drained();
      $display("Covered %0d transactions and %0d results: clear, add, full bone, query,",
               req_total, rsp_total);
      $display("bones in use extremes, ignored op code and a long receiver hold-off.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/nba_pkg.sv
rtl/nba_ctrl.sv
rtl/nba_dp.sv
rtl/nearest_bone_assign_unit.sv
sim/nearest_bone_assign_unit_tb.sv
